@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, with and without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is ignored while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds through reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dsac_pkg.sv @@
// ----------------------------------------------------------------------------
// dsac_pkg
// shared constants, tables and types of the slope / aspect / class pipeline
// ----------------------------------------------------------------------------
package dsac_pkg;

  localparam int CORDIC_ITERS = 23;
  localparam int XW           = 53;   // cordic x / y width, signed
  localparam int ZW           = 27;   // angle accumulator, 1/65536 degree
  localparam int SA_W         = 6;    // normalizing shift amount width
  localparam int NORM_MSB     = 48;   // operands are scaled so msb sits here
  localparam int KQ_FRAC      = 16;   // fraction bits of the cordic gain
  localparam int CORDIC_KQ    = 107922;
  localparam int DEG180       = 180 * 65536;
  localparam int ASPECT_FULL  = 92160;
  localparam int ASPECT_HALF  = 46080;
  localparam int SLOPE_MAX    = 23040;
  localparam int WATER_ELEV   = 8;
  localparam int WATER_SLOPE  = 256;
  localparam int ROUND_HALF   = 128;

  localparam int ATAN_TAB [CORDIC_ITERS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  // configuration register indexes
  localparam logic [2:0] REG_CELL_SIZE  = 3'd0;
  localparam logic [2:0] REG_LOW_MAX    = 3'd1;
  localparam logic [2:0] REG_HIGH_MIN   = 3'd2;
  localparam logic [2:0] REG_FLAT_MAX   = 3'd3;
  localparam logic [2:0] REG_STEEP_MIN  = 3'd4;

  // terrain classes
  localparam logic [2:0] CLS_LOW_FLAT   = 3'd0;
  localparam logic [2:0] CLS_LOW_GENTLE = 3'd1;
  localparam logic [2:0] CLS_PLATEAU    = 3'd2;
  localparam logic [2:0] CLS_MID_GENTLE = 3'd3;
  localparam logic [2:0] CLS_STEEP      = 3'd4;
  localparam logic [2:0] CLS_WATER      = 3'd5;

  typedef logic [14:0] slope_t;
  typedef logic [16:0] aspect_t;
  typedef logic [2:0]  terrain_class_t;

  typedef struct packed {
    terrain_class_t terrain_class;
    aspect_t        aspect_angle;
    slope_t         slope_angle;
  } out_item_t;

endpackage

@@ rtl/core/dsac_grad.sv @@
// ----------------------------------------------------------------------------
// dsac_grad
// horn gradients, magnitude bound and scaling of the aspect vector
// ----------------------------------------------------------------------------
module dsac_grad import dsac_pkg::*; #(
  parameter int ELEVATION_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [9*ELEVATION_WIDTH-1:0]      in_data,
  output logic                              out_valid,
  output logic signed [XW-1:0]              out_x,
  output logic signed [XW-1:0]              out_y,
  output logic                              out_neg,
  output logic [SA_W-1:0]                   out_sa,
  output logic                              out_flat,
  output logic signed [ELEVATION_WIDTH-1:0] out_center
);

  localparam int EW = ELEVATION_WIDTH;
  localparam int GW = EW + 3;
  localparam int MW = EW + 2;

  logic signed [EW-1:0] elev [9];
  logic signed [GW-1:0] e [9];

  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign elev[k] = in_data[k*EW +: EW];
    assign e[k]    = GW'(elev[k]);
  end

  // stage 1: gradients
  logic signed [GW-1:0] gx_nxt, gy_nxt, gx1_r, gy1_r;
  logic signed [EW-1:0] c1_r;
  logic                 v1_r;

  assign gx_nxt = (e[2] + (e[5] <<< 1) + e[8]) - (e[0] + (e[3] <<< 1) + e[6]);
  assign gy_nxt = (e[6] + (e[7] <<< 1) + e[8]) - (e[0] + (e[1] <<< 1) + e[2]);

  // stage 2: larger magnitude
  logic [GW-1:0]        ax_full, ay_full;
  logic [MW-1:0]        g_nxt, g2_r;
  logic signed [GW-1:0] gx2_r, gy2_r;
  logic signed [EW-1:0] c2_r;
  logic                 flat_nxt, flat2_r, v2_r;

  always_comb begin
    ax_full  = gx1_r[GW-1] ? -gx1_r : gx1_r;
    ay_full  = gy1_r[GW-1] ? -gy1_r : gy1_r;
    g_nxt    = (ax_full[MW-1:0] > ay_full[MW-1:0]) ? ax_full[MW-1:0] : ay_full[MW-1:0];
    flat_nxt = (gx1_r == '0) && (gy1_r == '0);
  end

  // stage 3: leading one search
  logic [SA_W-1:0]      msb, sa_nxt, sa3_r;
  logic signed [GW-1:0] gx3_r, gy3_r;
  logic signed [EW-1:0] c3_r;
  logic                 flat3_r, v3_r;

  always_comb begin
    msb = '0;
    for (int k = 0; k < MW; k++) begin
      if (g2_r[k]) msb = SA_W'(k);
    end
    sa_nxt = SA_W'(NORM_MSB) - msb;
  end

  // stage 4: fold into the right half plane and scale
  logic                 pos;
  logic signed [GW-1:0] xm, ym;
  logic signed [XW-1:0] x_nxt, y_nxt;

  always_comb begin
    pos   = !gx3_r[GW-1] && (gx3_r != '0);
    xm    = pos ? gx3_r : -gx3_r;
    ym    = pos ? -gy3_r : gy3_r;
    x_nxt = XW'(xm) <<< sa3_r;
    y_nxt = XW'(ym) <<< sa3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx1_r      <= gx_nxt;
      gy1_r      <= gy_nxt;
      c1_r       <= elev[4];
      gx2_r      <= gx1_r;
      gy2_r      <= gy1_r;
      g2_r       <= g_nxt;
      flat2_r    <= flat_nxt;
      c2_r       <= c1_r;
      gx3_r      <= gx2_r;
      gy3_r      <= gy2_r;
      sa3_r      <= sa_nxt;
      flat3_r    <= flat2_r;
      c3_r       <= c2_r;
      out_x      <= x_nxt;
      out_y      <= y_nxt;
      out_neg    <= pos;
      out_sa     <= sa3_r;
      out_flat   <= flat3_r;
      out_center <= c3_r;
    end
  end

endmodule

@@ rtl/core/dsac_cordic.sv @@
// ----------------------------------------------------------------------------
// dsac_cordic
// vectoring cordic, one registered iteration per stage, side data carried
// ----------------------------------------------------------------------------
module dsac_cordic import dsac_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [ZW-1:0] out_z,
  output logic [SW-1:0]        out_side
);

  logic signed [XW-1:0] x_r [CORDIC_ITERS];
  logic signed [XW-1:0] y_r [CORDIC_ITERS];
  logic signed [ZW-1:0] z_r [CORDIC_ITERS];
  logic [SW-1:0]        s_r [CORDIC_ITERS];
  logic                 v_r [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [XW-1:0] xs, ys, dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] zs, z_nxt;
    logic [SW-1:0]        ss;
    logic                 vs;

    if (i == 0) begin : g_first
      assign xs = in_x;
      assign ys = in_y;
      assign zs = in_z;
      assign ss = in_side;
      assign vs = in_valid;
    end else begin : g_next
      assign xs = x_r[i-1];
      assign ys = y_r[i-1];
      assign zs = z_r[i-1];
      assign ss = s_r[i-1];
      assign vs = v_r[i-1];
    end

    always_comb begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (!ys[XW-1]) begin
        x_nxt = xs + dx;
        y_nxt = ys - dy;
        z_nxt = zs + ZW'(ATAN_TAB[i]);
      end else begin
        x_nxt = xs - dx;
        y_nxt = ys + dy;
        z_nxt = zs - ZW'(ATAN_TAB[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        s_r[i] <= ss;
      end
    end
  end

  assign out_valid = v_r[CORDIC_ITERS-1];
  assign out_x     = x_r[CORDIC_ITERS-1];
  assign out_z     = z_r[CORDIC_ITERS-1];
  assign out_side  = s_r[CORDIC_ITERS-1];

endmodule

@@ rtl/core/dsac_sprep.sv @@
// ----------------------------------------------------------------------------
// dsac_sprep
// aspect rounding and operand setup for the slope cordic
// ----------------------------------------------------------------------------
module dsac_sprep import dsac_pkg::*; #(
  parameter int ELEVATION_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [15:0]                       cell_size,
  input  logic                              in_valid,
  input  logic signed [XW-1:0]              in_x,
  input  logic signed [ZW-1:0]              in_z,
  input  logic [SA_W-1:0]                   in_sa,
  input  logic                              in_flat,
  input  logic signed [ELEVATION_WIDTH-1:0] in_center,
  output logic                              out_valid,
  output logic signed [XW-1:0]              out_x,
  output logic signed [XW-1:0]              out_y,
  output logic                              out_flat,
  output logic signed [ELEVATION_WIDTH-1:0] out_center,
  output aspect_t                           out_aspect
);

  localparam int EW = ELEVATION_WIDTH;

  // stage 1: run length term and aspect rounding
  logic [15:0]          d;
  logic [32:0]          prod;
  logic signed [ZW-1:0] zr, asp;
  logic [35:0]          a1_r;
  logic [63:0]          b1_r;
  logic [SA_W-1:0]      sa1_r;
  logic                 flat1_r, v1_r;
  logic signed [EW-1:0] c1_r;
  aspect_t              asp1_r;

  always_comb begin
    d    = (cell_size == '0) ? 16'd1 : cell_size;
    prod = 33'(d) * 33'(CORDIC_KQ);
    zr   = (in_z + ZW'(ROUND_HALF)) >>> 8;
    if (zr < 0) begin
      asp = zr + ZW'(ASPECT_FULL);
    end else if (zr >= ZW'(ASPECT_FULL)) begin
      asp = zr - ZW'(ASPECT_FULL);
    end else begin
      asp = zr;
    end
  end

  // stage 2: bring both to a common scale
  logic [63:0]          a_al, b_al, a2_r, b2_r;
  logic                 flat2_r, v2_r;
  logic signed [EW-1:0] c2_r;
  aspect_t              asp2_r;

  always_comb begin
    if (sa1_r >= SA_W'(KQ_FRAC)) begin
      a_al = 64'(a1_r);
      b_al = b1_r >> (sa1_r - SA_W'(KQ_FRAC));
    end else begin
      a_al = 64'(a1_r) << (SA_W'(KQ_FRAC) - sa1_r);
      b_al = b1_r;
    end
  end

  // stage 3: leading one of the pair
  logic [63:0]          m;
  logic [5:0]           msb, msb3_r;
  logic [63:0]          a3_r, b3_r;
  logic                 flat3_r, v3_r;
  logic signed [EW-1:0] c3_r;
  aspect_t              asp3_r;

  always_comb begin
    m   = a2_r | b2_r;
    msb = '0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) msb = 6'(k);
    end
  end

  // stage 4: shift so the larger operand has its msb at NORM_MSB
  logic [63:0] a_n, b_n;

  always_comb begin
    if (msb3_r > 6'(NORM_MSB)) begin
      a_n = a3_r >> (msb3_r - 6'(NORM_MSB));
      b_n = b3_r >> (msb3_r - 6'(NORM_MSB));
    end else begin
      a_n = a3_r << (6'(NORM_MSB) - msb3_r);
      b_n = b3_r << (6'(NORM_MSB) - msb3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r       <= {prod, 3'b000};
      b1_r       <= 64'(in_x[XW-2:0]);
      sa1_r      <= in_sa;
      flat1_r    <= in_flat;
      c1_r       <= in_center;
      asp1_r     <= aspect_t'(asp);
      a2_r       <= a_al;
      b2_r       <= b_al;
      flat2_r    <= flat1_r;
      c2_r       <= c1_r;
      asp2_r     <= asp1_r;
      a3_r       <= a2_r;
      b3_r       <= b2_r;
      msb3_r     <= msb;
      flat3_r    <= flat2_r;
      c3_r       <= c2_r;
      asp3_r     <= asp2_r;
      out_x      <= $signed(a_n[XW-1:0]);
      out_y      <= $signed(b_n[XW-1:0]);
      out_flat   <= flat3_r;
      out_center <= c3_r;
      out_aspect <= asp3_r;
    end
  end

endmodule

@@ rtl/core/dsac_out.sv @@
// ----------------------------------------------------------------------------
// dsac_out
// slope rounding, terrain class and two-entry output skid buffer
// ----------------------------------------------------------------------------
module dsac_out import dsac_pkg::*; #(
  parameter int ELEVATION_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  output logic                              en,
  input  logic                              in_valid,
  input  logic signed [ZW-1:0]              in_z,
  input  logic                              in_flat,
  input  logic signed [ELEVATION_WIDTH-1:0] in_center,
  input  aspect_t                           in_aspect,
  input  logic signed [ELEVATION_WIDTH-1:0] low_max,
  input  logic signed [ELEVATION_WIDTH-1:0] high_min,
  input  slope_t                            flat_max,
  input  slope_t                            steep_min,
  output logic                              out_valid,
  input  logic                              out_ready,
  output out_item_t                         out_item
);

  localparam int EW = ELEVATION_WIDTH;

  // stage 1: slope rounding and flat window override
  logic signed [ZW-1:0] zr;
  slope_t               slope_nxt, slope_r;
  aspect_t              aspect_nxt, aspect_r;
  logic signed [EW-1:0] c_r;
  logic                 v_r;

  always_comb begin
    zr = (in_z + ZW'(ROUND_HALF)) >>> 8;
    if (in_flat) begin
      slope_nxt  = '0;
      aspect_nxt = aspect_t'(ASPECT_HALF);
    end else begin
      if (zr < 0) begin
        slope_nxt = '0;
      end else if (zr > ZW'(SLOPE_MAX)) begin
        slope_nxt = slope_t'(SLOPE_MAX);
      end else begin
        slope_nxt = slope_t'(zr);
      end
      aspect_nxt = in_aspect;
    end
  end

  // classification, water test first
  logic           water, low, high, flat, steep;
  terrain_class_t cls;
  out_item_t      item;

  always_comb begin
    water = (c_r < EW'(WATER_ELEV)) && (slope_r < slope_t'(WATER_SLOPE));
    low   = c_r <= low_max;
    high  = c_r >= high_min;
    flat  = slope_r <= flat_max;
    steep = slope_r >= steep_min;
    if (water) begin
      cls = CLS_WATER;
    end else if (high && steep) begin
      cls = CLS_STEEP;
    end else if (high) begin
      cls = CLS_PLATEAU;
    end else if (low && flat) begin
      cls = CLS_LOW_FLAT;
    end else if (low) begin
      cls = CLS_LOW_GENTLE;
    end else if (flat) begin
      cls = CLS_PLATEAU;
    end else if (steep) begin
      cls = CLS_STEEP;
    end else begin
      cls = CLS_MID_GENTLE;
    end
    item.terrain_class = cls;
    item.aspect_angle  = aspect_r;
    item.slope_angle   = slope_r;
  end

  // skid buffer: the pipeline only moves while a slot is free
  logic [1:0] cnt_r;
  out_item_t  d0_r, d1_r;
  logic       push, pop;

  assign en        = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = d0_r;
  assign push      = v_r && en;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (en) begin
        v_r <= in_valid;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slope_r  <= slope_nxt;
      aspect_r <= aspect_nxt;
      c_r      <= in_center;
    end
    if (pop && (cnt_r == 2'd2)) begin
      d0_r <= d1_r;
    end else if (push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))) begin
      d0_r <= item;
    end
    if (push && (cnt_r == 2'd1) && !pop) begin
      d1_r <= item;
    end
  end

endmodule

@@ rtl/core/dem_slope_aspect_classify.sv @@
// throughput: one request per cycle while the skid buffer has a free slot; the 23-stage aspect
//   and slope cordic pipelines never hold it, and the two-entry output skid buffer sets the
//   sustained rate: the whole pipeline holds while the skid buffer is full
// reset (rst_n low, synchronous) clears the valid bits and skid buffer and
//   loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// dem_slope_aspect_classify
// horn slope, aspect and terrain class of a 3x3 elevation window
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dem_slope_aspect_classify import dsac_pkg::*; #(
  parameter int ELEVATION_WIDTH = 20
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // nw, n, ne, w, center, e, sw, s, se from bit 0 up
  input  logic [((9*ELEVATION_WIDTH+7)/8)*8-1:0]      in_tdata,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // slope_angle, aspect_angle, terrain_class from bit 0 up
  output logic [39:0]                                 out_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [2:0]                                  cfg_index,
  input  logic [((ELEVATION_WIDTH > 16) ? ELEVATION_WIDTH : 16)-1:0] cfg_data
);

  localparam int EW = ELEVATION_WIDTH;

  // configuration registers
  logic [15:0]          cell_size_r;
  logic signed [EW-1:0] low_max_r, high_min_r;
  slope_t               flat_max_r, steep_min_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= 16'd480;
      low_max_r   <= EW'(3200);
      high_min_r  <= EW'(12800);
      flat_max_r  <= 15'd1280;
      steep_min_r <= 15'd6400;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_SIZE: cell_size_r <= cfg_data[15:0];
        REG_LOW_MAX:   low_max_r   <= cfg_data[EW-1:0];
        REG_HIGH_MIN:  high_min_r  <= cfg_data[EW-1:0];
        REG_FLAT_MAX:  flat_max_r  <= cfg_data[14:0];
        REG_STEEP_MIN: steep_min_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic pipe_en;
  assign in_tready = pipe_en;

  // gradients and aspect vector
  logic                 g_valid, g_neg, g_flat;
  logic signed [XW-1:0] g_x, g_y;
  logic [SA_W-1:0]      g_sa;
  logic signed [EW-1:0] g_center;

  dsac_grad #(.ELEVATION_WIDTH(EW)) u_grad (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_valid   (in_tvalid),
    .in_data    (in_tdata[9*EW-1:0]),
    .out_valid  (g_valid),
    .out_x      (g_x),
    .out_y      (g_y),
    .out_neg    (g_neg),
    .out_sa     (g_sa),
    .out_flat   (g_flat),
    .out_center (g_center)
  );

  // aspect cordic, side data {center, flat, sa}
  localparam int ASW = EW + 1 + SA_W;

  logic                 a_valid;
  logic signed [XW-1:0] a_x;
  logic signed [ZW-1:0] a_z;
  logic [ASW-1:0]       a_side;

  dsac_cordic #(.SW(ASW)) u_aspect (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (g_valid),
    .in_x      (g_x),
    .in_y      (g_y),
    .in_z      (g_neg ? ZW'(DEG180) : ZW'(0)),
    .in_side   ({g_center, g_flat, g_sa}),
    .out_valid (a_valid),
    .out_x     (a_x),
    .out_z     (a_z),
    .out_side  (a_side)
  );

  logic                 p_valid, p_flat;
  logic signed [XW-1:0] p_x, p_y;
  logic signed [EW-1:0] p_center;
  aspect_t              p_aspect;

  dsac_sprep #(.ELEVATION_WIDTH(EW)) u_sprep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .cell_size  (cell_size_r),
    .in_valid   (a_valid),
    .in_x       (a_x),
    .in_z       (a_z),
    .in_sa      (a_side[SA_W-1:0]),
    .in_flat    (a_side[SA_W]),
    .in_center  (a_side[ASW-1:SA_W+1]),
    .out_valid  (p_valid),
    .out_x      (p_x),
    .out_y      (p_y),
    .out_flat   (p_flat),
    .out_center (p_center),
    .out_aspect (p_aspect)
  );

  // slope cordic, side data {center, flat, aspect}
  localparam int SSW = EW + 1 + 17;

  logic                 s_valid;
  logic signed [XW-1:0] s_x;
  logic signed [ZW-1:0] s_z;
  logic [SSW-1:0]       s_side;

  dsac_cordic #(.SW(SSW)) u_slope (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (p_valid),
    .in_x      (p_x),
    .in_y      (p_y),
    .in_z      (ZW'(0)),
    .in_side   ({p_center, p_flat, p_aspect}),
    .out_valid (s_valid),
    .out_x     (s_x),
    .out_z     (s_z),
    .out_side  (s_side)
  );

  out_item_t out_item;

  dsac_out #(.ELEVATION_WIDTH(EW)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (s_valid && (s_x != '0 || s_x == '0)),
    .in_z      (s_z),
    .in_flat   (s_side[17]),
    .in_center (s_side[SSW-1:18]),
    .in_aspect (s_side[16:0]),
    .low_max   (low_max_r),
    .high_min  (high_min_r),
    .flat_max  (flat_max_r),
    .steep_min (steep_min_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = 40'(out_item);

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `ASSERT_CLK(a_class_range, out_tvalid |-> out_item.terrain_class <= CLS_WATER, "bad class")
  `ASSERT_CLK(a_angle_range, out_tvalid |-> (out_item.aspect_angle < aspect_t'(ASPECT_FULL)) && (out_item.slope_angle <= slope_t'(SLOPE_MAX)), "angle out of range")
  `ASSERT_CLK(a_hold_only_full, !pipe_en |-> out_tvalid && $past(out_tvalid), "stall without waiting result")

endmodule
